// File: hw/rtl/sas_pkg.sv
// Shared types and codes of the sprite animation sequencer.
package sas_pkg;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 120;
    localparam int KIND_W     = 3;

    localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LIST_ENTRY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LIST_LEN   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SET_ENTRY  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SET_LEN    = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SETRD,
        S_LISTRD,
        S_WAIT,
        S_TIME,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [15:0] dur_ms;
        logic [11:0] src_left;
        logic [11:0] src_top;
        logic [11:0] src_right;
        logic [11:0] src_bottom;
        logic [15:0] dest_x;
        logic [15:0] dest_y;
    } t_frame_rec;

endpackage

// File: hw/rtl/sas_frame_store.sv
// Frame table memory: duration, source rectangle and destination per frame.
module sas_frame_store #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  sas_pkg::t_frame_rec   i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output sas_pkg::t_frame_rec   o_rdata
);

    sas_pkg::t_frame_rec mem [DEPTH];
    sas_pkg::t_frame_rec r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_q <= mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// File: hw/rtl/sprite_animation_sequencer.sv
// Sprite animation sequencer top level: tables, frame stepping sequencer and stream ports.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: kind; tdata: elapsed, group, slot, value, duration, rectangle
//  m_axis    out        tuser: frame_valid; tdata: playing, frame, rectangle, size
//
// A write item passes decode and a wait state; an idle tick or unused kind goes straight to
// the result; a play reads the set, then the list. A tick while playing reads the list per
// frame step, the set first when a step enters a new list, and neither on the set's last step.
// Reset clears the sequencer state; the tables hold nothing defined until written.
// The input is taken only when the sequencer is idle; a stalled result stalls the next item
// at its result stage.
module sprite_animation_sequencer #(
    parameter int FRAME_COUNT = 256,
    parameter int LIST_COUNT  = 64,
    parameter int LIST_LEN    = 32,
    parameter int SET_COUNT   = 16,
    parameter int SET_LEN     = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // elapsed_ms, group, slot, entry_value, frame_duration, in_src_left, in_src_top,
    // in_src_right, in_src_bottom, in_dest_x, in_dest_y, zero pad
    input  logic [sas_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // kind
    input  logic [sas_pkg::KIND_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // playing, frame number, src_left, src_top, src_right, src_bottom, dest_x, dest_y,
    // dest_width, dest_height, zero pad
    output logic [sas_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // frame_valid
    output logic                                m_axis_tuser
);

    localparam int FRM_DEPTH = FRAME_COUNT < 256 ? FRAME_COUNT : 256;
    localparam int FRM_AW    = $clog2(FRM_DEPTH);
    localparam int LCNT      = LIST_COUNT < 64 ? LIST_COUNT : 64;
    localparam int LIST_W    = LCNT > 1 ? $clog2(LCNT) : 1;
    localparam int LLEN      = LIST_LEN < 256 ? LIST_LEN : 256;
    localparam int LLEN_MAX  = LIST_LEN < 255 ? LIST_LEN : 255;
    localparam int LPOS_W    = $clog2(LLEN_MAX + 1);
    localparam int LADR_W    = (LCNT * LLEN) > 1 ? $clog2(LCNT * LLEN) : 1;
    localparam int SCNT      = SET_COUNT < 64 ? SET_COUNT : 64;
    localparam int SET_W     = SCNT > 1 ? $clog2(SCNT) : 1;
    localparam int SLEN      = SET_LEN < 256 ? SET_LEN : 256;
    localparam int SLEN_MAX  = SET_LEN < 255 ? SET_LEN : 255;
    localparam int SPOS_W    = $clog2(SLEN_MAX + 1);
    localparam int SADR_W    = (SCNT * SLEN) > 1 ? $clog2(SCNT * SLEN) : 1;

    sas_pkg::t_state r_state, n_state;

    logic [sas_pkg::KIND_W-1:0] r_kind;
    logic [15:0] r_elapsed;
    logic [5:0]  r_group;
    logic [7:0]  r_slot;
    logic [7:0]  r_val;
    sas_pkg::t_frame_rec r_wrec;

    logic [31:0]       r_total, n_total;
    logic              r_playing, n_playing;
    logic              r_has_frame, n_has_frame;
    logic [SET_W-1:0]  r_act_set, n_act_set;
    logic [SPOS_W-1:0] r_spos, n_spos;
    logic [LIST_W-1:0] r_act_list, n_act_list;
    logic [LPOS_W-1:0] r_lpos, n_lpos;
    logic [7:0]        r_shown, n_shown;

    logic [7:0]        list_mem [LCNT * LLEN];
    logic [LIST_W-1:0] set_mem  [SCNT * SLEN];
    logic [LPOS_W-1:0] llen_mem [LCNT];
    logic [SPOS_W-1:0] slen_mem [SCNT];

    logic [7:0]        r_list_q;
    logic [LIST_W-1:0] r_set_q;
    logic [LPOS_W-1:0] r_llen_q;
    logic [SPOS_W-1:0] r_slen_q;

    logic [LADR_W-1:0] list_raddr, list_waddr;
    logic [SADR_W-1:0] set_raddr, set_waddr;
    logic              list_we, set_we, llen_we, slen_we, frm_we;
    logic [LPOS_W-1:0] llen_wdata;
    logic [SPOS_W-1:0] slen_wdata;

    sas_pkg::t_frame_rec frm_q;
    logic                frm_ok;
    logic [15:0]         dur;
    logic                over;
    logic [32:0]         sum;
    logic [LPOS_W:0]     lpos_inc;
    logic [SPOS_W:0]     spos_inc;
    logic                lpos_end, spos_end;
    logic                frm_slot_ok, list_grp_ok, set_grp_ok, play_ok;

    logic                           r_out_valid;
    logic [sas_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                           r_out_user;
    logic                           out_load;
    logic [sas_pkg::OUT_DATA_W-1:0] out_data;
    logic [11:0]                    o_l, o_t, o_r, o_b;
    logic [15:0]                    o_x, o_y;
    logic [12:0]                    o_w, o_h;

    assign s_axis_tready = (r_state == sas_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // hold the item
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_kind            <= s_axis_tuser;
            r_elapsed         <= s_axis_tdata[15:0];
            r_group           <= s_axis_tdata[21:16];
            r_slot            <= s_axis_tdata[29:22];
            r_val             <= s_axis_tdata[37:30];
            r_wrec.dur_ms     <= s_axis_tdata[53:38];
            r_wrec.src_left   <= s_axis_tdata[65:54];
            r_wrec.src_top    <= s_axis_tdata[77:66];
            r_wrec.src_right  <= s_axis_tdata[89:78];
            r_wrec.src_bottom <= s_axis_tdata[101:90];
            r_wrec.dest_x     <= s_axis_tdata[117:102];
            r_wrec.dest_y     <= s_axis_tdata[133:118];
        end
    end

    sas_frame_store #(
        .DEPTH (FRM_DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (frm_we),
        .i_waddr (r_slot[FRM_AW-1:0]),
        .i_wdata (r_wrec),
        .i_raddr (r_shown[FRM_AW-1:0]),
        .o_rdata (frm_q)
    );

    always_ff @(posedge i_clk) begin
        if (list_we) begin
            list_mem[list_waddr] <= r_val;
        end
        r_list_q <= list_mem[list_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (set_we) begin
            set_mem[set_waddr] <= r_val[LIST_W-1:0];
        end
        r_set_q <= set_mem[set_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (llen_we) begin
            llen_mem[r_group[LIST_W-1:0]] <= llen_wdata;
        end
        r_llen_q <= llen_mem[r_act_list];
    end

    always_ff @(posedge i_clk) begin
        if (slen_we) begin
            slen_mem[r_group[SET_W-1:0]] <= slen_wdata;
        end
        r_slen_q <= slen_mem[r_act_set];
    end

    assign frm_ok      = 32'(r_shown) < FRAME_COUNT;
    assign dur         = frm_ok ? frm_q.dur_ms : 16'd0;
    assign over        = r_total > {16'd0, dur};
    assign sum         = {1'b0, r_total} + {17'd0, r_elapsed};
    assign lpos_inc    = {1'b0, r_lpos} + (LPOS_W + 1)'(1);
    assign spos_inc    = {1'b0, r_spos} + (SPOS_W + 1)'(1);
    assign lpos_end    = lpos_inc >= {1'b0, r_llen_q};
    assign spos_end    = spos_inc >= {1'b0, r_slen_q};
    assign frm_slot_ok = 32'(r_slot) < FRAME_COUNT;
    assign list_grp_ok = 32'(r_group) < LIST_COUNT;
    assign set_grp_ok  = 32'(r_group) < SET_COUNT;
    assign play_ok     = set_grp_ok;
    assign out_load    = (r_state == sas_pkg::S_OUT) && (!r_out_valid || m_axis_tready);

    assign list_waddr = LADR_W'(r_group[LIST_W-1:0]) * LADR_W'(LLEN) + LADR_W'(r_slot);
    assign set_waddr  = SADR_W'(r_group[SET_W-1:0]) * SADR_W'(SLEN) + SADR_W'(r_slot);

    assign llen_wdata = (r_val == 8'd0) ? LPOS_W'(1)
                      : (32'(r_val) > LLEN_MAX) ? LPOS_W'(LLEN_MAX) : LPOS_W'(r_val);
    assign slen_wdata = (r_val == 8'd0) ? SPOS_W'(1)
                      : (32'(r_val) > SLEN_MAX) ? SPOS_W'(SLEN_MAX) : SPOS_W'(r_val);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sas_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = sas_pkg::S_DECODE;
                end
            end
            sas_pkg::S_DECODE: begin
                unique case (r_kind)
                    sas_pkg::KIND_TICK: begin
                        n_state = r_playing ? sas_pkg::S_TIME : sas_pkg::S_OUT;
                    end
                    sas_pkg::KIND_PLAY: begin
                        n_state = play_ok ? sas_pkg::S_SETRD : sas_pkg::S_OUT;
                    end
                    sas_pkg::KIND_FRAME, sas_pkg::KIND_LIST_ENTRY, sas_pkg::KIND_LIST_LEN,
                    sas_pkg::KIND_SET_ENTRY, sas_pkg::KIND_SET_LEN: begin
                        n_state = sas_pkg::S_WAIT;
                    end
                    default: begin
                        n_state = sas_pkg::S_OUT;
                    end
                endcase
            end
            sas_pkg::S_SETRD: begin
                n_state = sas_pkg::S_LISTRD;
            end
            sas_pkg::S_LISTRD: begin
                n_state = sas_pkg::S_WAIT;
            end
            sas_pkg::S_WAIT: begin
                n_state = (r_kind == sas_pkg::KIND_TICK) ? sas_pkg::S_TIME : sas_pkg::S_OUT;
            end
            sas_pkg::S_TIME: begin
                priority if (!over || (lpos_end && spos_end)) begin
                    n_state = sas_pkg::S_OUT;
                end else if (lpos_end) begin
                    n_state = sas_pkg::S_SETRD;
                end else begin
                    n_state = sas_pkg::S_LISTRD;
                end
            end
            sas_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = sas_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sas_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_total     = r_total;
        n_playing   = r_playing;
        n_has_frame = r_has_frame;
        n_act_set   = r_act_set;
        n_spos      = r_spos;
        n_act_list  = r_act_list;
        n_lpos      = r_lpos;
        n_shown     = r_shown;
        list_we     = 1'b0;
        set_we      = 1'b0;
        llen_we     = 1'b0;
        slen_we     = 1'b0;
        frm_we      = 1'b0;
        list_raddr  = LADR_W'(r_act_list) * LADR_W'(LLEN) + LADR_W'(lpos_inc);
        set_raddr   = SADR_W'(r_act_set) * SADR_W'(SLEN) + SADR_W'(spos_inc);
        unique case (r_state)
            sas_pkg::S_DECODE: begin
                unique case (r_kind)
                    sas_pkg::KIND_TICK: begin
                        if (r_playing) begin
                            n_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        end
                    end
                    sas_pkg::KIND_PLAY: begin
                        if (play_ok) begin
                            n_act_set   = r_group[SET_W-1:0];
                            n_spos      = '0;
                            n_playing   = 1'b1;
                            n_has_frame = 1'b1;
                        end
                        set_raddr = SADR_W'(r_group[SET_W-1:0]) * SADR_W'(SLEN);
                    end
                    sas_pkg::KIND_FRAME: begin
                        frm_we = frm_slot_ok;
                    end
                    sas_pkg::KIND_LIST_ENTRY: begin
                        list_we = list_grp_ok && (32'(r_slot) < LIST_LEN);
                    end
                    sas_pkg::KIND_LIST_LEN: begin
                        llen_we = list_grp_ok;
                    end
                    sas_pkg::KIND_SET_ENTRY: begin
                        set_we = set_grp_ok && (32'(r_slot) < SET_LEN)
                              && (32'(r_val) < LIST_COUNT);
                    end
                    sas_pkg::KIND_SET_LEN: begin
                        slen_we = set_grp_ok;
                    end
                    default: begin
                    end
                endcase
            end
            sas_pkg::S_SETRD: begin
                n_act_list = r_set_q;
                n_lpos     = '0;
                list_raddr = LADR_W'(r_set_q) * LADR_W'(LLEN);
            end
            sas_pkg::S_LISTRD: begin
                n_shown = r_list_q;
            end
            sas_pkg::S_TIME: begin
                if (over) begin
                    n_total = r_total - {16'd0, dur};
                    priority if (lpos_end && spos_end) begin
                        n_playing = 1'b0;
                    end else if (lpos_end) begin
                        n_spos = spos_inc[SPOS_W-1:0];
                    end else begin
                        n_lpos = lpos_inc[LPOS_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sas_pkg::S_IDLE;
            r_total     <= '0;
            r_playing   <= 1'b0;
            r_has_frame <= 1'b0;
            r_act_set   <= '0;
            r_spos      <= '0;
            r_act_list  <= '0;
            r_lpos      <= '0;
            r_shown     <= '0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_playing   <= n_playing;
            r_has_frame <= n_has_frame;
            r_act_set   <= n_act_set;
            r_spos      <= n_spos;
            r_act_list  <= n_act_list;
            r_lpos      <= n_lpos;
            r_shown     <= n_shown;
        end
    end

    assign o_l = (r_has_frame && frm_ok) ? frm_q.src_left   : 12'd0;
    assign o_t = (r_has_frame && frm_ok) ? frm_q.src_top    : 12'd0;
    assign o_r = (r_has_frame && frm_ok) ? frm_q.src_right  : 12'd0;
    assign o_b = (r_has_frame && frm_ok) ? frm_q.src_bottom : 12'd0;
    assign o_x = (r_has_frame && frm_ok) ? frm_q.dest_x     : 16'd0;
    assign o_y = (r_has_frame && frm_ok) ? frm_q.dest_y     : 16'd0;
    assign o_w = {1'b0, o_r} - {1'b0, o_l};
    assign o_h = {1'b0, o_b} - {1'b0, o_t};

    assign out_data = {5'd0, o_h, o_w, o_y, o_x, o_b, o_r, o_t, o_l,
                       (r_has_frame ? r_shown : 8'd0), (r_has_frame && r_playing)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= out_data;
            r_out_user <= r_has_frame;
        end
    end

endmodule
